[rtl/segment_windowed_hit_counter_assert.svh]
// Assertion macros for the segment windowed hit counter checker.
// Every macro expects signals named clk and arst_n where it is used.
`ifndef SEGMENT_WINDOWED_HIT_COUNTER_ASSERT_SVH
`define SEGMENT_WINDOWED_HIT_COUNTER_ASSERT_SVH

// Implication in the same cycle.
`define SWHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the next cycle.
`define SWHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/swhc_pkg.sv]
// Shared types, constants and helpers for the segment windowed hit counter.
// No dependencies.
package swhc_pkg;

	localparam int unsigned DEF_WINDOW_SLOTS  = 8;
	localparam int unsigned DEF_SEGMENT_COUNT = 256;

	localparam logic [15:0] MINUTE_LEN_RST     = 16'd60;
	localparam logic [15:0] TEN_MINUTE_LEN_RST = 16'd600;
	localparam logic [15:0] HOUR_LEN_RST       = 16'd3600;

	// Configuration register indexes
	localparam logic [1:0] CFG_MINUTE     = 2'd0;
	localparam logic [1:0] CFG_TEN_MINUTE = 2'd1;
	localparam logic [1:0] CFG_HOUR       = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic calc;
		logic head;
		logic slot;
	} swhc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_done;
	} swhc_sts_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

[rtl/swhc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swhc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/swhc_ctrl.sv]
// Controller state machine: clearing pass, then one request at a time.
// Depends on swhc_pkg.
module swhc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  swhc_pkg::swhc_sts_t sts,
	output swhc_pkg::swhc_cmd_t cmd,
	output logic                busy
);
	import swhc_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_CALC  = 5'b00100,
		ST_HEAD  = 5'b01000,
		ST_SLOT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clear_done) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_CALC;
			ST_CALC:  state_d = ST_HEAD;
			ST_HEAD:  state_d = ST_SLOT;
			ST_SLOT:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// command decode
	always_comb begin
		cmd.clear = (state_q == ST_CLEAR);
		cmd.load  = (state_q == ST_IDLE) && start;
		cmd.calc  = (state_q == ST_CALC);
		cmd.head  = (state_q == ST_HEAD);
		cmd.slot  = (state_q == ST_SLOT);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[rtl/swhc_datapath.sv]
// Datapath: segment record RAM, three history RAMs with per-segment ring
// pointers, window checks and result registers. Depends on swhc_pkg, swhc_ram.
module swhc_datapath #(
	parameter int unsigned WINDOW_SLOTS  = swhc_pkg::DEF_WINDOW_SLOTS,
	parameter int unsigned SEGMENT_COUNT = swhc_pkg::DEF_SEGMENT_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  swhc_pkg::swhc_cmd_t cmd,
	output swhc_pkg::swhc_sts_t sts,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [7:0]          segment_index,
	input  logic [31:0]         now_time,
	input  logic                object_was_active,
	input  logic [2:0]          read_slot,
	output logic                done,
	output logic [31:0]         hit_total,
	output logic [31:0]         active_total,
	output logic                object_now_active,
	output logic [31:0]         minute_slot_hits,
	output logic [31:0]         ten_minute_slot_hits,
	output logic [31:0]         hour_slot_hits,
	output logic [1:0]          levels_shifted
);
	import swhc_pkg::*;

	localparam int unsigned SAW = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
	localparam int unsigned PW  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int unsigned HD  = SEGMENT_COUNT * WINDOW_SLOTS;
	localparam int unsigned HAW = (HD > 1) ? $clog2(HD) : 1;
	localparam int unsigned RW  = 160 + 3 * PW;
	localparam int unsigned SW  = PW + 4;

	// window length registers
	logic [15:0] len_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[0] <= MINUTE_LEN_RST;
			len_q[1] <= TEN_MINUTE_LEN_RST;
			len_q[2] <= HOUR_LEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MINUTE:     len_q[0] <= cfg_data;
				CFG_TEN_MINUTE: len_q[1] <= cfg_data;
				CFG_HOUR:       len_q[2] <= cfg_data;
				default:        ;
			endcase
		end
	end

	// clearing pass counter
	logic [HAW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + HAW'(1);
		end
	end

	assign sts.clear_done = (clr_q == HAW'(HD - 1));

	// request capture
	logic [SAW-1:0] seg_q;
	logic [31:0]    now_q;
	logic           was_act_q;
	logic [2:0]     rslot_q;
	logic           seg_ok_q;
	logic           rslot_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seg_q      <= SAW'(segment_index);
			now_q      <= now_time;
			was_act_q  <= object_was_active;
			rslot_q    <= read_slot;
			seg_ok_q   <= 32'(segment_index) < 32'(SEGMENT_COUNT);
			rslot_ok_q <= 32'(read_slot) < 32'(WINDOW_SLOTS);
		end
	end

	// segment record RAM
	logic           seg_we;
	logic [SAW-1:0] seg_waddr;
	logic [RW-1:0]  seg_wdata;
	logic [RW-1:0]  rec;
	logic [RW-1:0]  rec_new;

	swhc_ram #(.WIDTH(RW), .DEPTH(SEGMENT_COUNT)) u_seg_ram (
		.clk   (clk),
		.we    (seg_we),
		.waddr (seg_waddr),
		.wdata (seg_wdata),
		.raddr (SAW'(segment_index)),
		.rdata (rec)
	);

	always_comb begin
		if (cmd.clear) begin
			seg_we    = 32'(clr_q) < 32'(SEGMENT_COUNT);
			seg_waddr = SAW'(clr_q);
			seg_wdata = '0;
		end else begin
			seg_we    = cmd.calc && seg_ok_q;
			seg_waddr = seg_q;
			seg_wdata = rec_new;
		end
	end

	// window checks and ring pointer update
	logic [31:0]    st    [3];
	logic [PW-1:0]  ptr   [3];
	logic           due   [3];
	logic           sh    [3];
	logic [31:0]    nst   [3];
	logic [PW-1:0]  nptr  [3];
	logic [HAW-1:0] haddr [3];
	logic [HAW-1:0] saddr [3];
	logic [SW-1:0]  ssum  [3];
	logic [HAW-1:0] base;
	logic [31:0]    nhit;
	logic [31:0]    nact;

	always_comb begin
		base = HAW'(32'(seg_q) * 32'(WINDOW_SLOTS));
		for (int l = 0; l < 3; l++) begin
			st[l]  = rec[64 + 32 * l +: 32];
			ptr[l] = rec[160 + PW * l +: PW];
			due[l] = (now_q >= st[l]) && ((now_q - st[l]) >= {16'd0, len_q[l]});
		end
		sh[0] = due[0];
		sh[1] = sh[0] && due[1];
		sh[2] = sh[1] && due[2];
		for (int l = 0; l < 3; l++) begin
			nst[l] = sh[l] ? now_q : st[l];
			if (!sh[l]) begin
				nptr[l] = ptr[l];
			end else if (ptr[l] == '0) begin
				nptr[l] = PW'(WINDOW_SLOTS - 1);
			end else begin
				nptr[l] = ptr[l] - PW'(1);
			end
			// logical slot read_slot sits read_slot places after the head
			ssum[l] = SW'(nptr[l]) + SW'(rslot_q);
			if (ssum[l] >= SW'(WINDOW_SLOTS)) begin
				ssum[l] = ssum[l] - SW'(WINDOW_SLOTS);
			end
			haddr[l] = base + HAW'(nptr[l]);
			saddr[l] = base + HAW'(ssum[l]);
		end
		nhit    = sat_inc(rec[31:0]);
		nact    = was_act_q ? rec[63:32] : sat_inc(rec[63:32]);
		rec_new = {nptr[2], nptr[1], nptr[0], nst[2], nst[1], nst[0], nact, nhit};
	end

	// results of the record step
	logic           sh_q    [3];
	logic [HAW-1:0] haddr_q [3];
	logic [HAW-1:0] saddr_q [3];
	logic [31:0]    hit_q;
	logic [31:0]    act_q;
	logic [1:0]     lvl_q;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			for (int l = 0; l < 3; l++) begin
				sh_q[l]    <= sh[l];
				haddr_q[l] <= haddr[l];
				saddr_q[l] <= saddr[l];
			end
			hit_q <= seg_ok_q ? nhit : 32'd0;
			act_q <= seg_ok_q ? nact : 32'd0;
			lvl_q <= seg_ok_q ? (2'(sh[0]) + 2'(sh[1]) + 2'(sh[2])) : 2'd0;
		end
	end

	// history RAMs, one per level
	logic [31:0] hrd     [3];
	logic [31:0] nhead   [3];
	logic [31:0] nhead_q [3];
	logic [31:0] slot_q  [3];

	for (genvar l = 0; l < 3; l++) begin : g_hist
		logic           h_we;
		logic [HAW-1:0] h_waddr;
		logic [HAW-1:0] h_raddr;
		logic [31:0]    h_wdata;

		// a freshly shifted head starts at one
		assign nhead[l] = sh_q[l] ? 32'd1 : sat_inc(hrd[l]);
		assign h_we     = cmd.clear || (cmd.head && seg_ok_q);
		assign h_waddr  = cmd.clear ? clr_q : haddr_q[l];
		assign h_wdata  = cmd.clear ? 32'd0 : nhead[l];
		assign h_raddr  = cmd.calc ? haddr[l] : saddr_q[l];

		swhc_ram #(.WIDTH(32), .DEPTH(HD)) u_hist_ram (
			.clk   (clk),
			.we    (h_we),
			.waddr (h_waddr),
			.wdata (h_wdata),
			.raddr (h_raddr),
			.rdata (hrd[l])
		);

		always_ff @(posedge clk) begin
			if (cmd.head) begin
				nhead_q[l] <= nhead[l];
			end
			if (cmd.slot) begin
				if (!seg_ok_q || !rslot_ok_q) begin
					slot_q[l] <= 32'd0;
				end else if (saddr_q[l] == haddr_q[l]) begin
					slot_q[l] <= nhead_q[l];
				end else begin
					slot_q[l] <= hrd[l];
				end
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.slot;
		end
	end

	assign hit_total            = hit_q;
	assign active_total         = act_q;
	assign object_now_active    = 1'b1;
	assign minute_slot_hits     = slot_q[0];
	assign ten_minute_slot_hits = slot_q[1];
	assign hour_slot_hits       = slot_q[2];
	assign levels_shifted       = lvl_q;

endmodule

[rtl/segment_windowed_hit_counter.sv]
// Segment windowed hit counter: a request is taken when start is high and busy low.
// The controller steps through its CALC, HEAD and SLOT states; the result strobe done
// is registered from SLOT and rises as busy falls, with the result on the outputs.
// A new request is taken only once the record read, history head
// read-modify-write and history slot read on single-port-read RAMs are through.
// Reset: a clearing pass over SEGMENT_COUNT*WINDOW_SLOTS addresses (2048 by default)
// zeroes all RAMs; busy stays high meanwhile. Configuration writes are always taken.
module segment_windowed_hit_counter #(
	parameter int unsigned WINDOW_SLOTS  = swhc_pkg::DEF_WINDOW_SLOTS,
	parameter int unsigned SEGMENT_COUNT = swhc_pkg::DEF_SEGMENT_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [7:0]  segment_index,
	input  logic [31:0] now_time,
	input  logic        object_was_active,
	input  logic [2:0]  read_slot,
	output logic        done,
	output logic [31:0] hit_total,
	output logic [31:0] active_total,
	output logic        object_now_active,
	output logic [31:0] minute_slot_hits,
	output logic [31:0] ten_minute_slot_hits,
	output logic [31:0] hour_slot_hits,
	output logic [1:0]  levels_shifted
);
	import swhc_pkg::*;

	swhc_cmd_t cmd;
	swhc_sts_t sts;

	assign cfg_ready = 1'b1;

	swhc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	swhc_datapath #(
		.WINDOW_SLOTS  (WINDOW_SLOTS),
		.SEGMENT_COUNT (SEGMENT_COUNT)
	) u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.cfg_valid            (cfg_valid),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.segment_index        (segment_index),
		.now_time             (now_time),
		.object_was_active    (object_was_active),
		.read_slot            (read_slot),
		.done                 (done),
		.hit_total            (hit_total),
		.active_total         (active_total),
		.object_now_active    (object_now_active),
		.minute_slot_hits     (minute_slot_hits),
		.ten_minute_slot_hits (ten_minute_slot_hits),
		.hour_slot_hits       (hour_slot_hits),
		.levels_shifted       (levels_shifted)
	);

endmodule

[rtl/swhc_checker.sv]
// Port-level checker for the segment windowed hit counter, bound to the top level.
// Depends on segment_windowed_hit_counter_assert.svh.
`include "segment_windowed_hit_counter_assert.svh"

module swhc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        object_now_active,
	input logic [31:0] hit_total,
	input logic [1:0]  levels_shifted
);

	// an accepted request makes the block busy next cycle
	`SWHC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")

	// the result comes out as the block goes idle again
	`SWHC_ASSERT_NOW(a_done_idle, done, !busy && $past(busy), "result strobe while busy")

	// no result in the cycle right after a request is taken
	`SWHC_ASSERT_NEXT(a_accept_no_done, start && !busy, !done, "result right after request")

	// the active mark is always set on a result
	`SWHC_ASSERT_NOW(a_active_mark, done, object_now_active, "active mark clear")

	// a zero hit total only comes from an ignored segment, which shifts nothing
	`SWHC_ASSERT_NOW(a_zero_total, done && hit_total == 32'd0, levels_shifted == 2'd0,
		"levels shifted on ignored segment")

endmodule

bind segment_windowed_hit_counter swhc_checker u_swhc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.start             (start),
	.busy              (busy),
	.done              (done),
	.object_now_active (object_now_active),
	.hit_total         (hit_total),
	.levels_shifted    (levels_shifted)
);
